// ----- rtl/tce_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tce_pkg
// Shared opcodes, constants and controller/datapath handshake structs for the
// toy CPU execute unit.
// ----------------------------------------------------------------------------
package tce_pkg;

   // Architectural sizes that do not vary
   localparam int NUM_REGS  = 5;
   localparam int REG_IDX_W = 3;
   localparam int IMM_W     = 32;
   localparam int PC_W      = 32;
   localparam int OPCODE_W  = 4;

   localparam logic [PC_W-1:0] PC_STEP = 32'd4;

   typedef enum logic [OPCODE_W-1:0] {
      OP_LOAD  = 4'd0,
      OP_MOVE  = 4'd1,
      OP_ADD   = 4'd2,
      OP_SUB   = 4'd3,
      OP_MUL   = 4'd4,
      OP_MOD   = 4'd5,
      OP_DIV   = 4'd6,
      OP_INC   = 4'd7,
      OP_DEC   = 4'd8,
      OP_EQ    = 4'd9,
      OP_GE    = 4'd10,
      OP_LE    = 4'd11,
      OP_SHIFT = 4'd12,
      OP_GOTO  = 4'd13,
      OP_JMPZ  = 4'd14,
      OP_JPNZ  = 4'd15
   } opcode_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic capture;      // latch the accepted instruction beat
      logic exec;         // evaluate the non-iterative result and bookkeeping
      logic start_iter;   // kick the iterative multiply/divide unit
      logic finish_iter;  // take the iterative result with sign fix-up
      logic commit;       // write state and load the response register
   } tce_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic iterative;    // current instruction needs the iterative unit
      logic iter_done;    // iterative unit has finished
   } tce_status_type;

endpackage : tce_pkg
`default_nettype wire

// ----- rtl/toy_cpu_execute_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Sequence: an accepted instruction passes READ, EXEC and POST, with ITER
//   between EXEC and POST for MUL, and for DIV and MOD with a nonzero divisor;
//   rsp_tvalid rises after the commit in POST, which waits for a free slot.
//   No new instruction is taken until the last is committed; ITER does one bit per cycle.
// Reset (synchronous, active high) clears the registers, PC, error flag and
//   code_base at once through per-register valid bits; no clearing pass.
// ----------------------------------------------------------------------------
// toy_cpu_execute_unit
// Execute stage of a small CPU: five general registers, PC and a sticky
// division error flag, one decoded instruction per request beat.
// ----------------------------------------------------------------------------
module toy_cpu_execute_unit #(
   parameter int DATA_WIDTH = 32
) (
   input  wire         clock,
   input  wire         reset,
   // Request: tdata = first_reg[2:0], second_reg[5:3], immediate[37:6], pad
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [39:0] req_tdata,
   // Request: tuser = opcode[3:0]
   input  wire  [3:0]  req_tuser,
   // Response: tdata = written_value[31:0], written_reg[34:32],
   //           pc_value[66:35], div_error[67], pad
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [71:0] rsp_tdata,
   // Response: tuser = wrote_reg[0]
   output logic [0:0]  rsp_tuser,
   // code_base register write
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [31:0] csr_data
);
   import tce_pkg::*;

   tce_cmd_type             cmd;
   tce_status_type          status;
   logic signed [IMM_W-1:0] written_value;
   logic [REG_IDX_W-1:0]    written_reg;
   logic                    wrote_reg;
   logic [PC_W-1:0]         pc_value;
   logic                    div_error;

   assign csr_ready = 1'b1;

   // Sequencer
   tce_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Datapath
   tce_datapath #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .in_opcode         (req_tuser),
      .in_first_reg      (req_tdata[2:0]),
      .in_second_reg     (req_tdata[5:3]),
      .in_immediate      (req_tdata[37:6]),
      .csr_write         (csr_valid && csr_ready),
      .csr_data          (csr_data),
      .out_written_value (written_value),
      .out_written_reg   (written_reg),
      .out_wrote_reg     (wrote_reg),
      .out_pc_value      (pc_value),
      .out_div_error     (div_error)
   );

   // Pack response beat
   assign rsp_tdata = {4'b0, div_error, pc_value, written_reg, written_value};
   assign rsp_tuser = wrote_reg;

   // Results are only posted into a free response slot
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_tvalid || rsp_tready))
      else $error("result posted over an untaken response beat");

   // Once an instruction is taken no second one enters until it completes
   assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> !req_tready)
      else $error("request accepted while an instruction is in flight");

   // Sequencer phases never overlap
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.exec, cmd.finish_iter, cmd.commit}))
      else $error("overlapping sequencer commands");

   // A posted result is visible on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_tvalid)
      else $error("committed result not presented");

endmodule : toy_cpu_execute_unit
`default_nettype wire

// ----- rtl/tce_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tce_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module tce_ram #(
   parameter int WIDTH      = 32,
   parameter int DEPTH      = 5,
   parameter int ADDR_WIDTH = $clog2(DEPTH)
) (
   input  wire                   clock,
   input  wire                   wr_en,
   input  wire  [ADDR_WIDTH-1:0] wr_addr,
   input  wire  [WIDTH-1:0]      wr_data,
   input  wire  [ADDR_WIDTH-1:0] rd_addr0,
   output logic [WIDTH-1:0]      rd_data0,
   input  wire  [ADDR_WIDTH-1:0] rd_addr1,
   output logic [WIDTH-1:0]      rd_data1
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read ports
   always_ff @(posedge clock) begin
      rd_data0 <= mem[rd_addr0];
      rd_data1 <= mem[rd_addr1];
   end

endmodule : tce_ram
`default_nettype wire

// ----- rtl/tce_muldiv.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tce_muldiv
// Iterative unsigned multiply (shift/add) and divide (restoring), one bit per
// cycle for WIDTH steps, with a one-cycle done pulse at the end.
// ----------------------------------------------------------------------------
module tce_muldiv #(
   parameter int WIDTH = 32
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              start,
   input  wire              is_div,
   input  wire  [WIDTH-1:0] op_a,      // multiplicand or dividend
   input  wire  [WIDTH-1:0] op_b,      // multiplier or divisor
   output logic             done,
   output logic [WIDTH-1:0] accum,     // product or remainder
   output logic [WIDTH-1:0] quotient
);

   localparam int CNT_W = $clog2(WIDTH);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic             div_ff;
   logic [CNT_W-1:0] count_ff;
   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH-1:0] shr_ff, shr_in;
   logic [WIDTH-1:0] shl_ff, shl_in;
   logic [WIDTH:0]   trial;

   // One step of the selected algorithm
   always_comb begin
      trial  = {acc_ff, shr_ff[WIDTH-1]} - {1'b0, shl_ff};
      acc_in = acc_ff;
      shr_in = shr_ff;
      shl_in = shl_ff;
      if (div_ff) begin
         if (!trial[WIDTH]) begin
            acc_in = trial[WIDTH-1:0];
            shr_in = {shr_ff[WIDTH-2:0], 1'b1};
         end else begin
            acc_in = {acc_ff[WIDTH-2:0], shr_ff[WIDTH-1]};
            shr_in = {shr_ff[WIDTH-2:0], 1'b0};
         end
      end else begin
         acc_in = acc_ff + (shr_ff[0] ? shl_ff : '0);
         shr_in = shr_ff >> 1;
         shl_in = shl_ff << 1;
      end
   end

   // Control: run WIDTH steps, then pulse done
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
      end else if (busy_ff && (count_ff == '0)) begin
         busy_in = 1'b0;
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Operand and step registers
   always_ff @(posedge clock) begin
      if (start) begin
         div_ff   <= is_div;
         count_ff <= CNT_W'(WIDTH - 1);
         acc_ff   <= '0;
         shr_ff   <= is_div ? op_a : op_b;
         shl_ff   <= is_div ? op_b : op_a;
      end else if (busy_ff) begin
         count_ff <= count_ff - 1'b1;
         acc_ff   <= acc_in;
         shr_ff   <= shr_in;
         shl_ff   <= shl_in;
      end
   end

   assign done     = done_ff;
   assign accum    = acc_ff;
   assign quotient = shr_ff;

endmodule : tce_muldiv
`default_nettype wire

// ----- rtl/tce_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tce_ctrl
// Instruction sequencer: accept, read operands, execute and, if needed, iterate,
// then post the result once the response register is free.
// ----------------------------------------------------------------------------
module tce_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  wire                     rsp_tready,
   input  tce_pkg::tce_status_type status,
   output tce_pkg::tce_cmd_type    cmd
);
   import tce_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_READ = 5'b00010,
      ST_EXEC = 5'b00100,
      ST_ITER = 5'b01000,
      ST_POST = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_tready;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.capture = req_tvalid;
            if (req_tvalid) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            cmd.exec       = 1'b1;
            cmd.start_iter = status.iterative;
            state_in       = status.iterative ? ST_ITER : ST_POST;
         end
         ST_ITER: begin
            cmd.finish_iter = status.iter_done;
            if (status.iter_done) begin
               state_in = ST_POST;
            end
         end
         ST_POST: begin
            cmd.commit = slot_free;
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response valid: set on commit, drop when the beat is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule : tce_ctrl
`default_nettype wire

// ----- rtl/tce_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tce_datapath
// Register file, ALU, shifter, branch logic, iterative multiply/divide and the
// response register of the execute unit.
// ----------------------------------------------------------------------------
module tce_datapath #(
   parameter int DATA_WIDTH = 32
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  tce_pkg::tce_cmd_type                 cmd,
   output tce_pkg::tce_status_type              status,
   input  wire  [tce_pkg::OPCODE_W-1:0]         in_opcode,
   input  wire  [tce_pkg::REG_IDX_W-1:0]        in_first_reg,
   input  wire  [tce_pkg::REG_IDX_W-1:0]        in_second_reg,
   input  wire  signed [tce_pkg::IMM_W-1:0]     in_immediate,
   input  wire                                  csr_write,
   input  wire  [tce_pkg::PC_W-1:0]             csr_data,
   output logic signed [tce_pkg::IMM_W-1:0]     out_written_value,
   output logic [tce_pkg::REG_IDX_W-1:0]        out_written_reg,
   output logic                                 out_wrote_reg,
   output logic [tce_pkg::PC_W-1:0]             out_pc_value,
   output logic                                 out_div_error
);
   import tce_pkg::*;

   localparam int SHW = $clog2(DATA_WIDTH);

   // Instruction register
   opcode_type              op_ff;
   logic [REG_IDX_W-1:0]    r1_ff, r2_ff;
   logic signed [IMM_W-1:0] imm_ff;

   // Architectural state
   logic [NUM_REGS-1:0]     valid_ff;
   logic [DATA_WIDTH-1:0]   rega_ff;
   logic [PC_W-1:0]         pc_ff;
   logic                    err_ff;
   logic [PC_W-1:0]         code_base_ff;

   // Operand read
   logic [DATA_WIDTH-1:0]   rdata_a, rdata_b;
   logic                    ok_a_ff, ok_b_ff;
   logic [DATA_WIDTH-1:0]   opa, opb;

   // Result staging
   logic [DATA_WIDTH-1:0]   val_ff, val_in;
   logic [REG_IDX_W-1:0]    dst_ff, dst_in;
   logic                    wr_ff, wr_in;
   logic [PC_W-1:0]         pc_res_ff, pc_res_in;
   logic                    err_res_ff, err_res_in;
   logic                    na_ff, nb_ff;

   // Execute helpers
   logic                    b_zero;
   logic                    neg_amt;
   logic [IMM_W-1:0]        amt;
   logic [DATA_WIDTH-1:0]   shift_val;
   logic [DATA_WIDTH-1:0]   mag_a, mag_b;
   logic                    md_is_div;
   logic                    md_done;
   logic [DATA_WIDTH-1:0]   md_accum, md_quot;
   logic [DATA_WIDTH-1:0]   fix_val;

   // Capture instruction beat
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= opcode_type'(in_opcode);
         r1_ff  <= in_first_reg;
         r2_ff  <= in_second_reg;
         imm_ff <= in_immediate;
      end
   end

   // Register file storage
   tce_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (NUM_REGS)
   ) u_regs (
      .clock    (clock),
      .wr_en    (cmd.commit && wr_ff),
      .wr_addr  (dst_ff),
      .wr_data  (val_ff),
      .rd_addr0 (r1_ff),
      .rd_data0 (rdata_a),
      .rd_addr1 (r2_ff),
      .rd_data1 (rdata_b)
   );

   // Unwritten and out-of-range registers read as zero
   always_ff @(posedge clock) begin
      ok_a_ff <= (32'(r1_ff) < NUM_REGS) ? valid_ff[r1_ff] : 1'b0;
      ok_b_ff <= (32'(r2_ff) < NUM_REGS) ? valid_ff[r2_ff] : 1'b0;
   end

   assign opa    = ok_a_ff ? rdata_a : '0;
   assign opb    = ok_b_ff ? rdata_b : '0;
   assign b_zero = (opb == '0);

   assign status.iterative = (op_ff == OP_MUL) ||
                             ((op_ff inside {OP_MOD, OP_DIV}) && !b_zero);
   assign status.iter_done = md_done;

   // Shift: right arithmetic for a positive amount, left for a negative one
   always_comb begin
      neg_amt = imm_ff[IMM_W-1];
      amt     = neg_amt ? (IMM_W'(0) - imm_ff) : imm_ff;
      if (amt == '0) begin
         shift_val = opa;
      end else if (!neg_amt) begin
         if (amt >= IMM_W'(DATA_WIDTH)) begin
            shift_val = {DATA_WIDTH{opa[DATA_WIDTH-1]}};
         end else begin
            shift_val = $signed(opa) >>> amt[SHW-1:0];
         end
      end else begin
         if (amt >= IMM_W'(DATA_WIDTH)) begin
            shift_val = '0;
         end else begin
            shift_val = opa << amt[SHW-1:0];
         end
      end
   end

   // Non-iterative results and bookkeeping
   always_comb begin
      val_in     = '0;
      dst_in     = '0;
      wr_in      = 1'b1;
      pc_res_in  = pc_ff;
      err_res_in = err_ff;
      case (op_ff)
         OP_LOAD: begin
            val_in = DATA_WIDTH'(imm_ff);
            dst_in = r1_ff;
         end
         OP_MOVE: begin
            val_in = opb;
            dst_in = r1_ff;
         end
         OP_ADD: val_in = opa + opb;
         OP_SUB: val_in = opa - opb;
         OP_MUL: val_in = '0;
         OP_MOD, OP_DIV: begin
            if (b_zero) begin
               wr_in      = 1'b0;
               err_res_in = 1'b1;
            end
         end
         OP_INC: begin
            val_in = opa + 1'b1;
            dst_in = r1_ff;
         end
         OP_DEC: begin
            val_in = opa - 1'b1;
            dst_in = r1_ff;
         end
         OP_EQ: val_in = DATA_WIDTH'(opa == opb);
         OP_GE: val_in = DATA_WIDTH'($signed(opa) >= $signed(opb));
         OP_LE: val_in = DATA_WIDTH'($signed(opb) >= $signed(opa));
         OP_SHIFT: begin
            val_in = shift_val;
            dst_in = r1_ff;
         end
         OP_GOTO: begin
            wr_in     = 1'b0;
            pc_res_in = code_base_ff + PC_W'(opa);
         end
         OP_JMPZ: begin
            wr_in     = 1'b0;
            pc_res_in = (rega_ff == '0) ? imm_ff : pc_ff + PC_STEP;
         end
         OP_JPNZ: begin
            wr_in     = 1'b0;
            pc_res_in = (rega_ff != '0) ? imm_ff : pc_ff + PC_STEP;
         end
         default: begin
            wr_in = 1'b0;
         end
      endcase
      // Drop writes to registers that do not exist
      if (32'(dst_in) >= NUM_REGS) begin
         wr_in = 1'b0;
      end
   end

   // Magnitudes for signed division
   assign mag_a     = opa[DATA_WIDTH-1] ? (DATA_WIDTH'(0) - opa) : opa;
   assign mag_b     = opb[DATA_WIDTH-1] ? (DATA_WIDTH'(0) - opb) : opb;
   assign md_is_div = (op_ff != OP_MUL);

   tce_muldiv #(
      .WIDTH (DATA_WIDTH)
   ) u_muldiv (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.start_iter),
      .is_div   (md_is_div),
      .op_a     (md_is_div ? mag_a : opa),
      .op_b     (md_is_div ? mag_b : opb),
      .done     (md_done),
      .accum    (md_accum),
      .quotient (md_quot)
   );

   // Sign fix-up: quotient by sign mismatch, remainder by dividend sign
   always_comb begin
      case (op_ff)
         OP_DIV:  fix_val = (na_ff ^ nb_ff) ? (DATA_WIDTH'(0) - md_quot) : md_quot;
         OP_MOD:  fix_val = na_ff ? (DATA_WIDTH'(0) - md_accum) : md_accum;
         default: fix_val = md_accum;
      endcase
   end

   // Result staging registers
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         val_ff     <= val_in;
         dst_ff     <= dst_in;
         wr_ff      <= wr_in;
         pc_res_ff  <= pc_res_in;
         err_res_ff <= err_res_in;
         na_ff      <= opa[DATA_WIDTH-1];
         nb_ff      <= opb[DATA_WIDTH-1];
      end else if (cmd.finish_iter) begin
         val_ff     <= fix_val;
      end
   end

   // Architectural state update
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rega_ff      <= '0;
         pc_ff        <= '0;
         err_ff       <= 1'b0;
         code_base_ff <= '0;
      end else begin
         if (cmd.commit) begin
            pc_ff  <= pc_res_ff;
            err_ff <= err_res_ff;
            if (wr_ff) begin
               valid_ff[dst_ff] <= 1'b1;
               if (dst_ff == '0) begin
                  rega_ff <= val_ff;
               end
            end
         end
         if (csr_write) begin
            code_base_ff <= csr_data;
         end
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         out_written_value <= wr_ff ? IMM_W'($signed(val_ff)) : '0;
         out_written_reg   <= wr_ff ? dst_ff : '0;
         out_wrote_reg     <= wr_ff;
         out_pc_value      <= pc_res_ff;
         out_div_error     <= err_res_ff;
      end
   end

endmodule : tce_datapath
`default_nettype wire

// ----- verif/toy_cpu_execute_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toy_cpu_execute_unit_test
// Self-checking bench for the execute unit. Instructions go in on the request
// stream and are also run on a behavioral copy of the registers, PC and error
// flag. Every response beat is checked field by field against the oldest
// pending prediction. A directed pass covers each opcode and corner case,
// then random phases run under different code_base values and stall patterns.
// ----------------------------------------------------------------------------
module toy_cpu_execute_unit_test;
   import tce_pkg::*;

   localparam int DATA_WIDTH         = 32;
   localparam int CYCLE_LIMIT        = 600000;
   localparam int LONG_HOLD_CYCLES   = 300;
   localparam int RANDOM_PHASES      = 6;
   localparam int RANDOM_PHASE_ITEMS = 300;
   localparam int SETTLE_CYCLES      = DATA_WIDTH + 8;

   // Register file indexes; the upper three codes address no register
   localparam logic [2:0] REG_A      = 3'd0;
   localparam logic [2:0] REG_B      = 3'd1;
   localparam logic [2:0] REG_C      = 3'd2;
   localparam logic [2:0] REG_D      = 3'd3;
   localparam logic [2:0] REG_E      = 3'd4;
   localparam logic [2:0] REG_VOID_5 = 3'd5;
   localparam logic [2:0] REG_VOID_7 = 3'd7;

   typedef enum logic [1:0] {
      RSP_ALWAYS_READY,
      RSP_RANDOM_STALL,
      RSP_PATTERN_STALL
   } rsp_stall_mode_type;

   typedef struct packed {
      logic [31:0] wr_value;
      logic [2:0]  wr_index;
      logic        wrote;
      logic [31:0] pc;
      logic        div_err;
   } exec_result_type;

   // DUT inputs, all known from time zero
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [39:0] req_tdata  = '0;
   logic [3:0]  req_tuser  = '0;
   logic        rsp_tready = 1'b0;
   logic        csr_valid  = 1'b0;
   logic [31:0] csr_data   = '0;

   logic        req_tready;
   logic        rsp_tvalid;
   logic [71:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        csr_ready;

   // Architectural state mirrored by the predictor
   logic [31:0] gpr_model [NUM_REGS] = '{default: '0};
   logic [31:0] pc_model        = '0;
   logic        err_model       = 1'b0;
   logic [31:0] code_base_model = '0;

   exec_result_type    pending_results[$];
   int                 fail_count    = 0;
   int                 cycle_count   = 0;
   int                 burst_left    = 0;
   bit                 send_gaps_en  = 1'b1;
   rsp_stall_mode_type rsp_stall_mode = RSP_RANDOM_STALL;
   int                 hold_req      = 0;
   int                 hold_seen     = 0;
   int                 hold_left     = 0;
   int                 stall_phase   = 0;

   toy_cpu_execute_unit #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Run one instruction on the mirrored state and return the expected beat
   function automatic exec_result_type execute_instr(opcode_type op, logic [2:0] first_idx,
                                                     logic [2:0] second_idx,
                                                     logic [31:0] imm);
      exec_result_type res;
      logic [31:0]     a;
      logic [31:0]     b;
      logic [31:0]     value;
      logic [31:0]     mag_a;
      logic [31:0]     mag_b;
      logic [31:0]     amount;
      logic [2:0]      dst;
      logic            do_write;
      a        = (first_idx < NUM_REGS) ? gpr_model[first_idx] : '0;
      b        = (second_idx < NUM_REGS) ? gpr_model[second_idx] : '0;
      value    = '0;
      dst      = REG_A;
      do_write = 1'b1;
      case (op)
         OP_LOAD: begin
            value = imm;
            dst   = first_idx;
         end
         OP_MOVE: begin
            value = b;
            dst   = first_idx;
         end
         OP_ADD: value = a + b;
         OP_SUB: value = a - b;
         OP_MUL: value = a * b;
         OP_MOD, OP_DIV: begin
            // zero divisor: set the sticky flag and leave A alone
            if (b == '0) begin
               err_model = 1'b1;
               do_write  = 1'b0;
            end else begin
               mag_a = a[31] ? -a : a;
               mag_b = b[31] ? -b : b;
               if (op == OP_DIV) begin
                  value = mag_a / mag_b;
                  if (a[31] != b[31]) value = -value;
               end else begin
                  value = mag_a % mag_b;
                  if (a[31]) value = -value;
               end
            end
         end
         OP_INC: begin
            value = a + 32'd1;
            dst   = first_idx;
         end
         OP_DEC: begin
            value = a - 32'd1;
            dst   = first_idx;
         end
         OP_EQ: value = {31'd0, a == b};
         OP_GE: value = {31'd0, $signed(a) >= $signed(b)};
         OP_LE: value = {31'd0, $signed(b) >= $signed(a)};
         OP_SHIFT: begin
            // positive amount shifts right with sign, negative shifts left
            dst    = first_idx;
            amount = imm[31] ? -imm : imm;
            if (amount == '0) begin
               value = a;
            end else if (!imm[31]) begin
               if (amount >= DATA_WIDTH) value = {32{a[31]}};
               else value = $signed(a) >>> amount;
            end else begin
               if (amount >= DATA_WIDTH) value = '0;
               else value = a << amount;
            end
         end
         OP_GOTO: begin
            do_write = 1'b0;
            pc_model = code_base_model + a;
         end
         OP_JMPZ: begin
            do_write = 1'b0;
            pc_model = (gpr_model[REG_A] == '0) ? imm : pc_model + PC_STEP;
         end
         OP_JPNZ: begin
            do_write = 1'b0;
            pc_model = (gpr_model[REG_A] != '0) ? imm : pc_model + PC_STEP;
         end
      endcase
      // drop writes aimed past register E
      if (dst >= NUM_REGS) do_write = 1'b0;
      if (do_write) gpr_model[dst] = value;
      res.wr_value = do_write ? value : '0;
      res.wr_index = do_write ? dst : '0;
      res.wrote    = do_write;
      res.pc       = pc_model;
      res.div_err  = err_model;
      return res;
   endfunction

   // Offer one instruction beat, idling between bursts, and predict on accept
   task automatic send_instr(opcode_type op, logic [2:0] first_idx,
                             logic [2:0] second_idx, logic [31:0] imm);
      int gap;
      if (send_gaps_en && burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, imm, second_idx, first_idx};
      req_tuser  <= op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_results.push_back(execute_instr(op, first_idx, second_idx, imm));
      if (burst_left > 0) burst_left--;
   endtask

   task automatic send_random_instr();
      opcode_type  op;
      logic [2:0]  first_idx;
      logic [2:0]  second_idx;
      logic [31:0] imm;
      // lean toward loads so operands keep changing
      if ($urandom_range(0, 4) == 0) op = OP_LOAD;
      else op = opcode_type'(4'($urandom_range(0, 15)));
      first_idx  = ($urandom_range(0, 11) == 0) ? 3'($urandom_range(5, 7))
                                                : 3'($urandom_range(0, 4));
      second_idx = ($urandom_range(0, 11) == 0) ? 3'($urandom_range(5, 7))
                                                : 3'($urandom_range(0, 4));
      case ($urandom_range(0, 3))
         0: imm = $urandom();
         1: imm = $urandom_range(0, 80) - 40;
         2: begin
            case ($urandom_range(0, 4))
               0:       imm = 32'h8000_0000;
               1:       imm = 32'h7FFF_FFFF;
               2:       imm = 32'hFFFF_FFFF;
               3:       imm = 32'h0000_0000;
               default: imm = 32'h0000_0001;
            endcase
         end
         default: imm = $urandom_range(0, 15);
      endcase
      send_instr(op, first_idx, second_idx, imm);
   endtask

   // Hold the request side until every response is back and the unit is idle
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_code_base(logic [31:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      code_base_model = value;
   endtask

   task automatic test_load_and_move();
      send_instr(OP_LOAD, REG_A, REG_A, 32'h7FFF_FFFF);
      send_instr(OP_LOAD, REG_B, REG_A, 32'h8000_0000);
      send_instr(OP_LOAD, REG_C, REG_A, 32'hFFFF_FFFF);
      send_instr(OP_MOVE, REG_D, REG_B, 32'h0000_0000);
   endtask

   // Wrap at both ends of the signed range
   task automatic test_arith_wrap();
      send_instr(OP_ADD, REG_A, REG_A, 32'h0);
      send_instr(OP_SUB, REG_B, REG_C, 32'h0);
      send_instr(OP_MUL, REG_B, REG_B, 32'h0);
      send_instr(OP_INC, REG_C, REG_A, 32'h0);
      send_instr(OP_DEC, REG_D, REG_A, 32'h0);
   endtask

   task automatic test_compares();
      send_instr(OP_EQ, REG_B, REG_D, 32'h0);
      send_instr(OP_GE, REG_B, REG_D, 32'h0);
      send_instr(OP_LE, REG_B, REG_D, 32'h0);
   endtask

   // Single-bit moves, saturation both ways, zero and most negative amounts
   task automatic test_shifts();
      send_instr(OP_SHIFT, REG_B, REG_A, 32'h0000_0001);
      send_instr(OP_SHIFT, REG_B, REG_A, 32'hFFFF_FFFF);
      send_instr(OP_SHIFT, REG_B, REG_A, 32'h0000_0020);
      send_instr(OP_SHIFT, REG_D, REG_A, 32'hFFFF_FFE0);
      send_instr(OP_SHIFT, REG_C, REG_A, 32'h8000_0000);
      send_instr(OP_SHIFT, REG_B, REG_A, 32'h0000_0000);
   endtask

   // Register jump wraps past the top; conditional jumps taken and not taken
   task automatic test_jumps();
      drain_results();
      write_code_base(32'hFFFF_FFF0);
      send_instr(OP_GOTO, REG_B, REG_A, 32'h0);
      send_instr(OP_JPNZ, REG_A, REG_A, 32'h0000_1234);
      send_instr(OP_LOAD, REG_A, REG_A, 32'h0);
      send_instr(OP_JMPZ, REG_A, REG_A, 32'hFFFF_FFFC);
      send_instr(OP_JPNZ, REG_A, REG_A, 32'h0000_5678);
   endtask

   // Indexes past E read as zero and never write
   task automatic test_unmapped_regs();
      send_instr(OP_LOAD, REG_VOID_5, REG_A, 32'h1234_5678);
      send_instr(OP_MOVE, REG_A, REG_VOID_7, 32'h0);
      send_instr(OP_INC, REG_VOID_7, REG_A, 32'h0);
   endtask

   // Most negative over minus one, then zero divisors for both operations
   task automatic test_divide();
      send_instr(OP_LOAD, REG_A, REG_A, 32'h8000_0000);
      send_instr(OP_DIV, REG_A, REG_B, 32'h0);
      send_instr(OP_MOD, REG_A, REG_B, 32'h0);
      send_instr(OP_DIV, REG_A, REG_E, 32'h0);
      send_instr(OP_MOD, REG_A, REG_E, 32'h0);
   endtask

   // Stall the response side for a long stretch while requests keep coming
   task automatic test_response_backpressure();
      drain_results();
      rsp_stall_mode = RSP_ALWAYS_READY;
      send_gaps_en   = 1'b0;
      hold_req++;
      repeat (24) send_random_instr();
      drain_results();
   endtask

   task automatic test_random_phases();
      logic [31:0] base_values [RANDOM_PHASES];
      base_values = '{32'hFFFF_FFFF, 32'h0000_0000, $urandom(), 32'hFFFF_FFFC,
                      $urandom(), 32'h0000_0001};
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_results();
         write_code_base(base_values[phase]);
         rsp_stall_mode = rsp_stall_mode_type'(phase % 3);
         send_gaps_en   = (phase != 3);
         repeat (RANDOM_PHASE_ITEMS) send_random_instr();
      end
   endtask

   // Response ready: long holds on request, otherwise the current pattern
   always @(posedge clock) begin
      if (hold_seen != hold_req) begin
         hold_seen  <= hold_req;
         hold_left  <= LONG_HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         stall_phase <= (stall_phase == 10) ? 0 : stall_phase + 1;
         case (rsp_stall_mode)
            RSP_RANDOM_STALL:  rsp_tready <= ($urandom_range(0, 2) != 0);
            RSP_PATTERN_STALL: rsp_tready <= (stall_phase < 7);
            default:           rsp_tready <= 1'b1;
         endcase
      end
   end

   // Compare each accepted response beat with the oldest prediction
   always @(posedge clock) begin : rsp_check
      exec_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("response beat with nothing outstanding: tdata %h", rsp_tdata);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[31:0] !== want.wr_value) begin
               $error("written_value: expected %h, got %h", want.wr_value, rsp_tdata[31:0]);
               fail_count++;
            end
            if (rsp_tdata[34:32] !== want.wr_index) begin
               $error("written_reg: expected %0d, got %0d", want.wr_index, rsp_tdata[34:32]);
               fail_count++;
            end
            if (rsp_tuser[0] !== want.wrote) begin
               $error("wrote_reg: expected %0b, got %0b", want.wrote, rsp_tuser[0]);
               fail_count++;
            end
            if (rsp_tdata[66:35] !== want.pc) begin
               $error("pc_value: expected %h, got %h", want.pc, rsp_tdata[66:35]);
               fail_count++;
            end
            if (rsp_tdata[67] !== want.div_err) begin
               $error("div_error: expected %0b, got %0b", want.div_err, rsp_tdata[67]);
               fail_count++;
            end
         end
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("toy_cpu_execute_unit test failed");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_load_and_move();
      test_arith_wrap();
      test_compares();
      test_shifts();
      test_jumps();
      test_unmapped_regs();
      test_divide();
      test_response_backpressure();
      test_random_phases();
      drain_results();
      if (fail_count == 0) begin
         $display("toy_cpu_execute_unit test passed");
      end else begin
         $display("toy_cpu_execute_unit test failed");
      end
      $finish;
   end

endmodule
